[rtl/core/apsp_pkg.sv]
// Shared types and constants for the all-pairs shortest path block.
`timescale 1ns / 1ps
`default_nettype none
package apsp_pkg;

  localparam int VIDX_W = 3;
  localparam int DOUT_W = 16;
  localparam int WIN_W  = 16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [VIDX_W-1:0] row;
    logic [VIDX_W-1:0] col;
    logic [WIN_W-1:0]  weight;
    logic              no_edge;
  } in_t;

  typedef struct packed {
    logic [VIDX_W-1:0] src;
    logic [VIDX_W-1:0] dst;
    logic [DOUT_W-1:0] distance;
    logic              reachable;
    logic [VIDX_W-1:0] pred;
    logic              has_pred;
    logic              last;
  } out_t;

  // Per-cycle commands from the sequencer to every column cell.
  typedef struct packed {
    logic init;
    logic prep;
    logic relax;
    logic rotate;
    logic load_stage;
    logic shift_stage;
  } ctl_t;

endpackage
`default_nettype wire

[rtl/core/apsp_cell.sv]
// One column cell: holds one matrix column as a rotating line and relaxes its head entry.
`timescale 1ns / 1ps
`default_nettype none
module apsp_cell import apsp_pkg::*; #(
  parameter int VERTICES    = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire ctl_t                          ctl,
  input  wire logic [$clog2(VERTICES)-1:0]   k_sel,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(VERTICES)-1:0]   wr_row,
  input  wire logic [WEIGHT_BITS+4:0]        wr_ent,
  input  wire logic [WEIGHT_BITS+4:0]        bc_ent,
  input  wire logic [WEIGHT_BITS+4:0]        right_stage,
  output logic      [WEIGHT_BITS+4:0]        head,
  output logic      [WEIGHT_BITS+4:0]        stage
);

  // Entry layout: {inf, pred_valid, pred, dist}
  localparam int DW    = WEIGHT_BITS;
  localparam int EW    = WEIGHT_BITS + 5;
  localparam int INF_B = EW - 1;
  localparam int PV_B  = EW - 2;

  logic [EW-1:0] ent_r [VERTICES];
  logic [EW-1:0] rk_r;
  logic [EW-1:0] stage_r;
  logic [EW-1:0] upd;
  logic [DW:0]   sum;
  logic [DW-1:0] sat;
  logic          better;

  assign head  = ent_r[0];
  assign stage = stage_r;

  always_comb begin
    sum    = {1'b0, bc_ent[DW-1:0]} + {1'b0, rk_r[DW-1:0]};
    sat    = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
    better = !bc_ent[INF_B] && !rk_r[INF_B] &&
             (head[INF_B] || (head[DW-1:0] > sat));
    upd    = head;
    if (better) begin
      upd[INF_B]    = 1'b0;
      upd[DW-1:0]   = sat;
      if (rk_r[PV_B]) begin
        upd[PV_B]       = 1'b1;
        upd[DW+2:DW]    = rk_r[DW+2:DW];
      end else begin
        upd[PV_B]       = bc_ent[PV_B];
        upd[DW+2:DW]    = bc_ent[DW+2:DW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      for (int p = 0; p < VERTICES; p++) begin
        if (!ent_r[p][INF_B] && (ent_r[p][DW-1:0] != '0)) begin
          ent_r[p][PV_B]     <= 1'b1;
          ent_r[p][DW+2:DW]  <= VIDX_W'(p);
        end else begin
          ent_r[p][PV_B]     <= 1'b0;
          ent_r[p][DW+2:DW]  <= '0;
        end
      end
    end else if (ctl.rotate) begin
      for (int p = 0; p < VERTICES - 1; p++) begin
        ent_r[p] <= ent_r[p+1];
      end
      ent_r[VERTICES-1] <= ctl.relax ? upd : head;
    end else if (wr_en) begin
      ent_r[wr_row] <= wr_ent;
    end
    if (ctl.prep) begin
      rk_r <= ent_r[k_sel];
    end
    if (ctl.load_stage) begin
      stage_r <= head;
    end else if (ctl.shift_stage) begin
      stage_r <= right_stage;
    end
  end

endmodule
`default_nettype wire

[rtl/core/all_pairs_shortest_path.sv]
// Top level: Floyd-Warshall all-pairs shortest path over a chain of column cells.
//
//   channel | ports                      | transfer when
//   --------+----------------------------+-------------------------------
//   input   | start, busy, in_data       | start high and busy low
//   result  | out_valid, out_data        | out_valid high (one cycle each)
//
// A load item writes one entry of the matrix.
// A run item keeps busy high through one predecessor setup step, then per
// intermediate vertex a step to latch its row followed by relaxation (all
// columns in parallel, one source row per cycle), then one result per cycle
// in row-major order.
// Reset clears the sequencer and the result strobe only; matrix contents
// are undefined until written. The result side cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module all_pairs_shortest_path import apsp_pkg::*; #(
  parameter int VERTICES    = 8,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int IW = $clog2(VERTICES);
  localparam int DW = WEIGHT_BITS;
  localparam int EW = WEIGHT_BITS + 5;
  localparam logic [IW-1:0] LAST_IDX = IW'(VERTICES - 1);

  typedef enum logic [2:0] {IDLE, INIT, PREP, RELAX, EMIT} state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;
  ctl_t          ctl;

  logic [EW-1:0] heads  [VERTICES];
  logic [EW-1:0] stages [VERTICES];
  logic [EW-1:0] bc_ent;
  logic [EW-1:0] wr_ent;
  logic [EW-1:0] sel_ent;
  logic [WIN_W+31:0] w_wide;
  logic [DW+15:0]    d_wide;
  logic          accept;
  logic          load_ok;

  assign busy      = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign accept    = start && !busy;

  // Drop loads aimed outside the configured vertex range.
  assign load_ok = accept && (in_data.action == ACT_LOAD) &&
                   ({1'b0, in_data.row} < 4'(VERTICES)) &&
                   ({1'b0, in_data.col} < 4'(VERTICES));

  // Mask or extend the load weight to the internal width.
  assign w_wide = {32'd0, in_data.weight};
  assign wr_ent = {in_data.no_edge, 1'b0, 3'd0,
                   in_data.no_edge ? {DW{1'b0}} : w_wide[DW-1:0]};

  // Column k's head is d(i,k) for the row currently at the heads.
  assign bc_ent = heads[k_r];

  always_comb begin
    ctl             = '0;
    ctl.init        = (state_r == INIT);
    ctl.prep        = (state_r == PREP);
    ctl.relax       = (state_r == RELAX);
    ctl.rotate      = (state_r == RELAX) || ((state_r == EMIT) && (j_r == '0));
    ctl.load_stage  = (state_r == EMIT) && (j_r == '0);
    ctl.shift_stage = (state_r == EMIT) && (j_r != '0);
  end

  for (genvar c = 0; c < VERTICES; c++) begin : g_cell
    logic [EW-1:0] right;
    if (c == VERTICES - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid
      assign right = stages[c+1];
    end
    apsp_cell #(
      .VERTICES    (VERTICES),
      .WEIGHT_BITS (WEIGHT_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .k_sel       (k_r),
      .wr_en       (load_ok && (in_data.col[IW-1:0] == IW'(c))),
      .wr_row      (in_data.row[IW-1:0]),
      .wr_ent      (wr_ent),
      .bc_ent      (bc_ent),
      .right_stage (right),
      .head        (heads[c]),
      .stage       (stages[c])
    );
  end

  // Column 0 comes straight from the heads; later columns arrive through the stage chain.
  assign sel_ent = (j_r == '0) ? heads[0] : stages[1];
  assign d_wide  = {16'd0, sel_ent[DW-1:0]};

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      IDLE: begin
        if (accept && (in_data.action == ACT_RUN)) begin
          state_nxt = INIT;
          k_nxt     = '0;
        end
      end
      INIT: begin
        state_nxt = PREP;
      end
      PREP: begin
        state_nxt = RELAX;
        i_nxt     = '0;
      end
      RELAX: begin
        i_nxt = i_r + 1'b1;
        if (i_r == LAST_IDX) begin
          i_nxt = '0;
          if (k_r == LAST_IDX) begin
            state_nxt = EMIT;
            j_nxt     = '0;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = PREP;
          end
        end
      end
      EMIT: begin
        out_valid_nxt     = 1'b1;
        out_nxt.src       = VIDX_W'(i_r);
        out_nxt.dst       = VIDX_W'(j_r);
        out_nxt.reachable = !sel_ent[EW-1];
        out_nxt.distance  = sel_ent[EW-1] ? '0 : d_wide[15:0];
        out_nxt.has_pred  = sel_ent[EW-2];
        out_nxt.pred      = sel_ent[EW-2] ? sel_ent[DW+2:DW] : '0;
        out_nxt.last      = (i_r == LAST_IDX) && (j_r == LAST_IDX);
        j_nxt = j_r + 1'b1;
        if (j_r == LAST_IDX) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
          if (i_r == LAST_IDX) begin
            i_nxt     = '0;
            state_nxt = IDLE;
          end
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.action == ACT_RUN)) |=> busy)
    else $error("run transfer did not raise busy");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == EMIT))
    else $error("result strobe outside emit phase");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> (state_r == IDLE))
    else $error("last result while sequencer still running");

  a_no_pred_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_pred) |-> (out_data.pred == '0))
    else $error("pred not cleared without valid predecessor");

endmodule
`default_nettype wire
